// File: hdl/htfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 byte update for the humidity and
// temperature frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [15:0] ROUND_HALF  = 16'd32767;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [13:0] HUM_MAX     = 14'd10000;

    localparam int TEMP_PROD_W = 31;
    localparam int HUM_PROD_W  = 30;

    typedef enum logic [2:0] {
        POS_T_MSB = 3'd0,
        POS_T_LSB = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_MSB = 3'd3,
        POS_H_LSB = 3'd4,
        POS_H_CRC = 3'd5
    } byte_pos_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// File: hdl/htfd_rx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_rx_if
// Request channel that carries one received frame byte.
// ----------------------------------------------------------------------------
interface htfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// File: hdl/htfd_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_res_if
// Request channel that carries one decoded reading with its status.
// ----------------------------------------------------------------------------
interface htfd_res_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic signed [14:0] temperature_cdeg;
    logic        [13:0] humidity_cpct;

    modport source (output valid, output status, output temperature_cdeg,
                    output humidity_cpct, input ready);
    modport sink   (input valid, input status, input temperature_cdeg,
                    input humidity_cpct, output ready);
endinterface

// File: hdl/htfd_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_convert
// Divides the rounded scaled products by 65535 and maps them to centidegrees
// and clamped centipercent.
// ----------------------------------------------------------------------------
module htfd_convert
    import htfd_pkg::*;
(
    input  logic [TEMP_PROD_W-1:0] prod_t,
    input  logic [HUM_PROD_W-1:0]  prod_h,
    output logic signed [14:0]     temperature_cdeg,
    output logic [13:0]            humidity_cpct
);

    // For x below 65535 * 65536 the quotient x / 65535 equals
    // (x + (x >> 16) + 1) >> 16.
    logic [31:0] sum_t;
    logic [31:0] sum_h;
    logic [15:0] quo_t;
    logic [15:0] quo_h;
    logic [15:0] cdeg;

    assign sum_t = 32'(prod_t) + 32'(prod_t >> 16) + 32'd1;
    assign sum_h = 32'(prod_h) + 32'(prod_h >> 16) + 32'd1;
    assign quo_t = sum_t[31:16];
    assign quo_h = sum_h[31:16];

    assign cdeg             = quo_t - TEMP_OFFSET;
    assign temperature_cdeg = signed'(cdeg[14:0]);
    assign humidity_cpct    = (quo_h > 16'(HUM_MAX)) ? HUM_MAX : quo_h[13:0];

endmodule

// File: hdl/humidity_temp_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Assembles six-byte sensor frames, checks both CRC-8 bytes and converts a
// good frame into the last good temperature and humidity reading.
// ----------------------------------------------------------------------------
// The result of a frame becomes valid after its sixth byte is taken, passing
// through the multiplier register and then the result register.
// Throughput: one byte per cycle; the scaling multipliers and result register
// each hold one frame, so input stalls only when both are held by a stalled
// result. Reset clears the byte position, CRC, raw words and last good
// values to their initial state and empties both stages.
module humidity_temp_frame_decoder
    import htfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    htfd_rx_if.sink    rx,
    htfd_res_if.source res
);

    byte_pos_t pos_reg, pos_next, pos_eff;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  hi_reg, hi_next;
    logic [15:0] raw_t_reg, raw_t_next;
    logic [15:0] raw_h_reg, raw_h_next;
    logic        t_ok_reg, t_ok_next;

    logic                   a_valid_reg, a_valid_next;
    logic                   a_ok_reg, a_ok_next;
    logic [TEMP_PROD_W-1:0] a_prod_t_reg, a_prod_t_next;
    logic [HUM_PROD_W-1:0]  a_prod_h_reg, a_prod_h_next;

    logic               res_valid_reg, res_valid_next;
    logic               status_reg, status_next;
    logic signed [14:0] good_t_reg, good_t_next;
    logic [13:0]        good_h_reg, good_h_next;

    logic               rx_take;
    logic               res_adv;
    logic               a_move;
    logic               frame_done;
    logic signed [14:0] conv_t;
    logic [13:0]        conv_h;

    assign res_adv  = !res_valid_reg || res.ready;
    assign a_move   = a_valid_reg && res_adv;
    assign rx.ready = !a_valid_reg || res_adv;
    assign rx_take  = rx.valid && rx.ready;
    assign pos_eff  = rx.frame_start ? POS_T_MSB : pos_reg;

    always_comb
    begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        hi_next       = hi_reg;
        raw_t_next    = raw_t_reg;
        raw_h_next    = raw_h_reg;
        t_ok_next     = t_ok_reg;
        frame_done    = 1'b0;
        a_ok_next     = a_ok_reg;
        a_prod_t_next = a_prod_t_reg;
        a_prod_h_next = a_prod_h_reg;
        if (rx_take)
        begin
            case (pos_eff)
                POS_T_LSB:
                begin
                    crc_next   = crc8_byte(crc_reg, rx.rx_byte);
                    raw_t_next = {hi_reg, rx.rx_byte};
                    pos_next   = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    t_ok_next = (crc_reg == rx.rx_byte);
                    crc_next  = CRC_INIT;
                    pos_next  = POS_H_MSB;
                end
                POS_H_MSB:
                begin
                    crc_next = crc8_byte(CRC_INIT, rx.rx_byte);
                    hi_next  = rx.rx_byte;
                    pos_next = POS_H_LSB;
                end
                POS_H_LSB:
                begin
                    crc_next   = crc8_byte(crc_reg, rx.rx_byte);
                    raw_h_next = {hi_reg, rx.rx_byte};
                    pos_next   = POS_H_CRC;
                end
                POS_H_CRC:
                begin
                    crc_next      = CRC_INIT;
                    pos_next      = POS_T_MSB;
                    frame_done    = 1'b1;
                    a_ok_next     = t_ok_reg && (crc_reg == rx.rx_byte);
                    a_prod_t_next = TEMP_PROD_W'(raw_t_reg) * TEMP_PROD_W'(TEMP_SPAN)
                                    + TEMP_PROD_W'(ROUND_HALF);
                    a_prod_h_next = HUM_PROD_W'(raw_h_reg) * HUM_PROD_W'(HUM_SPAN)
                                    + HUM_PROD_W'(ROUND_HALF);
                end
                default:
                begin
                    crc_next = crc8_byte(CRC_INIT, rx.rx_byte);
                    hi_next  = rx.rx_byte;
                    pos_next = POS_T_LSB;
                end
            endcase
        end
    end

    always_comb
    begin
        if (frame_done)
        begin
            a_valid_next = 1'b1;
        end
        else if (res_adv)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end

        res_valid_next = res_valid_reg;
        status_next    = status_reg;
        good_t_next    = good_t_reg;
        good_h_next    = good_h_reg;
        if (a_move)
        begin
            res_valid_next = 1'b1;
            status_next    = !a_ok_reg;
            if (a_ok_reg)
            begin
                good_t_next = conv_t;
                good_h_next = conv_h;
            end
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    htfd_convert u_convert (
        .prod_t           (a_prod_t_reg),
        .prod_h           (a_prod_h_reg),
        .temperature_cdeg (conv_t),
        .humidity_cpct    (conv_h)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_T_MSB;
            crc_reg       <= CRC_INIT;
            hi_reg        <= '0;
            raw_t_reg     <= '0;
            raw_h_reg     <= '0;
            t_ok_reg      <= 1'b0;
            a_valid_reg   <= 1'b0;
            a_ok_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            status_reg    <= 1'b0;
            good_t_reg    <= '0;
            good_h_reg    <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            hi_reg        <= hi_next;
            raw_t_reg     <= raw_t_next;
            raw_h_reg     <= raw_h_next;
            t_ok_reg      <= t_ok_next;
            a_valid_reg   <= a_valid_next;
            a_ok_reg      <= a_ok_next;
            res_valid_reg <= res_valid_next;
            status_reg    <= status_next;
            good_t_reg    <= good_t_next;
            good_h_reg    <= good_h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_prod_t_reg <= a_prod_t_next;
        a_prod_h_reg <= a_prod_h_next;
    end

    assign res.valid            = res_valid_reg;
    assign res.status           = status_reg;
    assign res.temperature_cdeg = good_t_reg;
    assign res.humidity_cpct    = good_h_reg;

endmodule

// File: hdl/htfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_checker
// Port-level checks on the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module htfd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               rx_valid,
    input logic               rx_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic               status,
    input logic signed [14:0] temperature_cdeg,
    input logic [13:0]        humidity_cpct
);

    logic signed [14:0] last_t_reg;
    logic [13:0]        last_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_t_reg <= '0;
            last_h_reg <= '0;
        end
        else if (res_valid && res_ready)
        begin
            last_t_reg <= temperature_cdeg;
            last_h_reg <= humidity_cpct;
        end
    end

    // A stalled result keeps its status and values.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status)
            && $stable(temperature_cdeg) && $stable(humidity_cpct))
    else $error("stalled result changed");

    // A failed frame repeats the previously delivered reading.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status |-> temperature_cdeg == last_t_reg
            && humidity_cpct == last_h_reg)
    else $error("checksum failure altered the reading");

    // A good reading lies within the sensor range.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !status |-> humidity_cpct <= 14'd10000
            && temperature_cdeg >= -15'sd4500 && temperature_cdeg <= 15'sd13000)
    else $error("good reading out of range");

    // A new result follows a taken byte through the multiplier and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(rx_valid && rx_ready, 2))
    else $error("result appeared without a closing byte");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rx_valid         (rx.valid),
    .rx_ready         (rx.ready),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .status           (res.status),
    .temperature_cdeg (res.temperature_cdeg),
    .humidity_cpct    (res.humidity_cpct)
);
